>>> hdl/ternary_kleene_store_macros.svh
// Assertion macros used by the checker file
`ifndef TERNARY_KLEENE_STORE_MACROS_SVH
`define TERNARY_KLEENE_STORE_MACROS_SVH

// Implication checked every clock, masked while reset is asserted
`define TKS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define TKS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tks_pkg.sv
package tks_pkg;

  localparam int unsigned TksMaxTrits = 1024;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_AND   = 3'd2,
    OP_OR    = 3'd3,
    OP_NOT   = 3'd4,
    OP_TRIM  = 3'd5,
    OP_COUNT = 3'd6
  } tks_op_e;

  typedef enum logic [1:0] {
    TRIT_UNK   = 2'd0,
    TRIT_FALSE = 2'd1,
    TRIT_TRUE  = 2'd2
  } tks_trit_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_TRIM,
    ST_SEARCH,
    ST_DONE
  } tks_state_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] position;
    logic [1:0]  operand_trit;
  } tks_in_t;

  typedef struct packed {
    logic [1:0]  read_trit;
    logic [10:0] known_length;
    logic [10:0] match_count;
    logic        range_error;
  } tks_out_t;

  // code three reads as Unknown
  function automatic logic [1:0] norm_trit(input logic [1:0] t);
    norm_trit = (t == 2'd3) ? TRIT_UNK : t;
  endfunction

endpackage

>>> hdl/tks_ram.sv
module tks_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/tks_alu.sv
module tks_alu import tks_pkg::*; (
  input  logic [2:0] op_i,
  input  logic [1:0] cur_i,
  input  logic [1:0] opnd_i,
  output logic [1:0] new_o
);

  always_comb begin
    new_o = cur_i;
    unique case (op_i)
      OP_WRITE: new_o = opnd_i;
      OP_AND: begin
        if (cur_i == TRIT_FALSE || opnd_i == TRIT_FALSE) new_o = TRIT_FALSE;
        else if (cur_i == TRIT_UNK || opnd_i == TRIT_UNK) new_o = TRIT_UNK;
        else new_o = TRIT_TRUE;
      end
      OP_OR: begin
        if (cur_i == TRIT_TRUE || opnd_i == TRIT_TRUE) new_o = TRIT_TRUE;
        else if (cur_i == TRIT_UNK || opnd_i == TRIT_UNK) new_o = TRIT_UNK;
        else new_o = TRIT_FALSE;
      end
      OP_NOT: begin
        if (cur_i == TRIT_FALSE) new_o = TRIT_TRUE;
        else if (cur_i == TRIT_TRUE) new_o = TRIT_FALSE;
        else new_o = TRIT_UNK;
      end
      default: new_o = cur_i;
    endcase
  end

endmodule

>>> hdl/ternary_kleene_store.sv
// Channel  | Valid       | Stall        | Payload
// input    | in_valid_i  | in_stall_o   | in_data_i  (tks_in_t)
// output   | out_valid_o | out_stall_i  | out_data_o (tks_out_t)
//
// Read/write/and/or/not/count: RAM read, then modify and write back.
// Trim: clears each entry from the position up to the length, then the backward search.
// Backward search: one RAM read per position stepped.
// After reset the RAM is swept to Unknown, with the input stalled.
// A finished result waits in the output register; the next transaction is
// accepted meanwhile, and the block holds in its done state only if that
// register still holds a stalled result when the following result is ready.
module ternary_kleene_store import tks_pkg::*; #(
  parameter int unsigned MaxTrits = TksMaxTrits
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tks_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tks_out_t out_data_o
);

  localparam int unsigned AW = $clog2(MaxTrits);
  localparam int unsigned LW = $clog2(MaxTrits + 1);
  localparam logic [16:0] MaxPos = 17'(MaxTrits);
  localparam logic [LW-1:0] LastIdx = LW'(MaxTrits - 1);

  tks_state_e state_q, state_d;
  logic [LW-1:0] idx_q, idx_d, lim_q, lim_d, len_q, len_d;
  logic [LW-1:0] f_q, f_d, t_q, t_d;
  logic [AW-1:0] pend_addr_q, pend_addr_d, pos_q, pos_d;
  logic          pend_q, pend_d, err_q, err_d;
  logic [2:0]    op_q, op_d;
  logic [1:0]    opnd_q, opnd_d, rd_q, rd_d;
  logic [10:0]   cnt_q, cnt_d;
  tks_out_t      out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [1:0]    ram_wdata, rdata, new_trit;

  logic in_acc, out_free, in_range, rmw_wr, rmw_search, trim_go;
  logic trim_issue, trim_end, s_hit, s_end, finish;
  logic [LW-1:0] pos_ext;

  tks_ram #(.Width(2), .Depth(MaxTrits)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(rdata)
  );

  tks_alu u_alu (
    .op_i  (op_q),
    .cur_i (rdata),
    .opnd_i(opnd_q),
    .new_o (new_trit)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign in_range    = {1'b0, in_data_i.position} < MaxPos;
  assign pos_ext     = LW'(pos_q);
  // writing Unknown at or beyond the length leaves everything as it is
  assign rmw_wr      = (op_q == OP_WRITE || op_q == OP_AND || op_q == OP_OR ||
                        op_q == OP_NOT) &&
                       !(pos_ext >= len_q && new_trit == TRIT_UNK);
  assign rmw_search  = rmw_wr && new_trit == TRIT_UNK && (pos_ext + LW'(1)) == len_q;
  assign trim_go     = (op_q == OP_TRIM) && (pos_ext < len_q);
  assign trim_issue  = idx_q < len_q;
  assign trim_end    = !trim_issue && !pend_q;
  assign s_hit       = pend_q && rdata != TRIT_UNK;
  assign s_end       = s_hit || lim_q == '0;
  assign finish      = (state_q == ST_RMW || state_q == ST_SEARCH || state_q == ST_DONE) &&
                       state_d == ST_IDLE;

  function automatic logic [AW-1:0] lim_d_addr(input logic [LW-1:0] lim);
    logic [LW-1:0] dec;
    dec = lim - LW'(1);
    lim_d_addr = dec[AW-1:0];
  endfunction

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (idx_q == LastIdx) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) state_d = in_range ? ST_RMW : ST_DONE;
      end
      ST_RMW: begin
        if (trim_go) state_d = ST_TRIM;
        else if (rmw_search) state_d = ST_SEARCH;
        else state_d = out_free ? ST_IDLE : ST_DONE;
      end
      ST_TRIM:   if (trim_end) state_d = ST_SEARCH;
      ST_SEARCH: if (s_end) state_d = out_free ? ST_IDLE : ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    lim_d       = lim_q;
    len_d       = len_q;
    f_d         = f_q;
    t_d         = t_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    pos_d       = pos_q;
    op_d        = op_q;
    opnd_d      = opnd_q;
    err_d       = err_q;
    rd_d        = rd_q;
    cnt_d       = cnt_q;
    ram_we      = 1'b0;
    ram_waddr   = pos_q;
    ram_wdata   = TRIT_UNK;
    ram_raddr   = pos_q;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        idx_d     = idx_q + LW'(1);
      end
      ST_IDLE: begin
        ram_raddr = in_data_i.position[AW-1:0];
        if (in_acc) begin
          op_d   = in_data_i.opcode;
          pos_d  = in_data_i.position[AW-1:0];
          opnd_d = norm_trit(in_data_i.operand_trit);
          err_d  = !in_range;
          rd_d   = TRIT_UNK;
          cnt_d  = '0;
        end
      end
      ST_RMW: begin
        rd_d = (op_q == OP_TRIM) ? TRIT_UNK : (rmw_wr ? new_trit : rdata);
        if (op_q == OP_COUNT) begin
          if (opnd_q == TRIT_FALSE) cnt_d = 11'(f_q);
          else if (opnd_q == TRIT_TRUE) cnt_d = 11'(t_q);
          else cnt_d = 11'(len_q - f_q - t_q);
        end
        if (rmw_wr) begin
          ram_we    = 1'b1;
          ram_wdata = new_trit;
          f_d = f_q - LW'(rdata == TRIT_FALSE) + LW'(new_trit == TRIT_FALSE);
          t_d = t_q - LW'(rdata == TRIT_TRUE) + LW'(new_trit == TRIT_TRUE);
          if (pos_ext >= len_q) len_d = pos_ext + LW'(1);
        end
        if (rmw_search) begin
          lim_d  = pos_ext;
          pend_d = 1'b0;
        end
        if (trim_go) begin
          idx_d  = pos_ext;
          pend_d = 1'b0;
        end
      end
      ST_TRIM: begin
        // read ahead one entry, clear the one whose old value has just arrived
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr_q;
          f_d = f_q - LW'(rdata == TRIT_FALSE);
          t_d = t_q - LW'(rdata == TRIT_TRUE);
        end
        pend_d = trim_issue;
        if (trim_issue) begin
          ram_raddr   = idx_q[AW-1:0];
          pend_addr_d = idx_q[AW-1:0];
          idx_d       = idx_q + LW'(1);
        end
        if (trim_end) lim_d = pos_ext;
      end
      ST_SEARCH: begin
        if (s_hit) begin
          len_d = LW'(pend_addr_q) + LW'(1);
        end else if (lim_q == '0) begin
          len_d = '0;
        end else begin
          ram_raddr   = lim_d_addr(lim_q);
          pend_addr_d = lim_d_addr(lim_q);
          pend_d      = 1'b1;
          lim_d       = lim_q - LW'(1);
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    if (finish) begin
      out_valid_d              = 1'b1;
      out_d.read_trit          = rd_d;
      out_d.known_length       = 11'(len_d);
      out_d.match_count        = cnt_d;
      out_d.range_error        = err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      lim_q       <= '0;
      len_q       <= '0;
      f_q         <= '0;
      t_q         <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      lim_q       <= lim_d;
      len_q       <= len_d;
      f_q         <= f_d;
      t_q         <= t_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    pos_q       <= pos_d;
    op_q        <= op_d;
    opnd_q      <= opnd_d;
    err_q       <= err_d;
    rd_q        <= rd_d;
    cnt_q       <= cnt_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/tks_checker.sv
`include "ternary_kleene_store_macros.svh"

module tks_checker import tks_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input tks_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input tks_out_t out_data_o
);

  `TKS_ASSERT_NEXT(a_out_held, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `TKS_ASSERT_IMPL(a_err_clean, out_valid_o && out_data_o.range_error, out_data_o.read_trit == TRIT_UNK && out_data_o.match_count == 11'd0, "range error with payload")
  `TKS_ASSERT_IMPL(a_trit_code, out_valid_o, out_data_o.read_trit != 2'd3, "illegal trit code")
  `TKS_ASSERT_NEXT(a_busy_after, in_valid_i && !in_stall_o, in_stall_o, "second transaction taken while busy")

endmodule

bind ternary_kleene_store tks_checker u_tks_checker (.*);

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tks_pkg::*;

  localparam int unsigned Depth = TksMaxTrits;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  tks_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  tks_out_t out_data_o;

  ternary_kleene_store dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // predictor state
  logic [1:0]  shadow_trits [Depth];
  int unsigned shadow_len;
  int unsigned shadow_false;
  int unsigned shadow_true;

  tks_out_t expected_results [$];
  int unsigned mismatches;
  bit          rx_busy;
  int unsigned rx_wait;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic logic [1:0] kl_and(logic [1:0] a, logic [1:0] b);
    if (a == TRIT_FALSE || b == TRIT_FALSE) return TRIT_FALSE;
    if (a == TRIT_UNK || b == TRIT_UNK) return TRIT_UNK;
    return TRIT_TRUE;
  endfunction

  function automatic logic [1:0] kl_or(logic [1:0] a, logic [1:0] b);
    if (a == TRIT_TRUE || b == TRIT_TRUE) return TRIT_TRUE;
    if (a == TRIT_UNK || b == TRIT_UNK) return TRIT_UNK;
    return TRIT_FALSE;
  endfunction

  function automatic int unsigned last_known_below(int unsigned lim);
    for (int i = int'(lim); i > 0; i--)
      if (shadow_trits[i-1] != TRIT_UNK) return i;
    return 0;
  endfunction

  function automatic void store_trit(int unsigned p, logic [1:0] v);
    if (shadow_trits[p] == TRIT_FALSE) shadow_false--;
    if (shadow_trits[p] == TRIT_TRUE) shadow_true--;
    if (v == TRIT_FALSE) shadow_false++;
    if (v == TRIT_TRUE) shadow_true++;
    shadow_trits[p] = v;
  endfunction

  function automatic void assign_trit(int unsigned p, logic [1:0] v);
    if (p >= shadow_len) begin
      if (v == TRIT_UNK) return;
      store_trit(p, v);
      shadow_len = p + 1;
      return;
    end
    store_trit(p, v);
    if (v == TRIT_UNK && p + 1 == shadow_len) shadow_len = last_known_below(p);
  endfunction

  function automatic tks_out_t predict_access(tks_in_t it);
    tks_out_t r;
    logic [1:0] opnd, cur;
    int unsigned p;
    r = '0;
    opnd = (it.operand_trit == 2'd3) ? TRIT_UNK : it.operand_trit;
    if (it.position >= Depth) begin
      r.range_error = 1'b1;
    end else begin
      p = 32'(it.position);
      cur = shadow_trits[p];
      case (it.opcode)
        OP_WRITE: assign_trit(p, opnd);
        OP_AND:   assign_trit(p, kl_and(cur, opnd));
        OP_OR:    assign_trit(p, kl_or(cur, opnd));
        OP_NOT:   assign_trit(p, cur == TRIT_FALSE ? TRIT_TRUE :
                              cur == TRIT_TRUE ? TRIT_FALSE : TRIT_UNK);
        OP_TRIM: begin
          if (p < shadow_len) begin
            for (int unsigned i = p; i < shadow_len; i++) store_trit(i, TRIT_UNK);
            shadow_len = last_known_below(p);
          end
        end
        OP_COUNT: begin
          if (opnd == TRIT_FALSE) r.match_count = 11'(shadow_false);
          else if (opnd == TRIT_TRUE) r.match_count = 11'(shadow_true);
          else r.match_count = 11'(shadow_len - shadow_false - shadow_true);
        end
        default: ;
      endcase
      r.read_trit = shadow_trits[p];
    end
    r.known_length = shadow_len[10:0];
    return r;
  endfunction

  task automatic send_access(logic [2:0] op, logic [15:0] pos, logic [1:0] t);
    tks_in_t it;
    int unsigned gap;
    it.opcode = op;
    it.position = pos;
    it.operand_trit = t;
    gap = $urandom_range(3) == 0 ? 0 : $urandom_range(18);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_results.push_back(predict_access(it));
  endtask

  // receiver stall: a fresh wait drawn per result, counted while a result is offered
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait = 0;
    end else if (out_valid_o && !out_stall_i) begin
      rx_wait = rx_busy ? $urandom_range(18) : 0;
      out_stall_i <= (rx_wait != 0);
    end else if (out_valid_o && rx_wait != 0) begin
      rx_wait--;
      if (rx_wait == 0) out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    tks_out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data_o);
      end else begin
        e = expected_results.pop_front();
        if (out_data_o !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: trit %0d/%0d len %0d/%0d cnt %0d/%0d err %0d/%0d",
                     e.read_trit, out_data_o.read_trit, e.known_length,
                     out_data_o.known_length, e.match_count, out_data_o.match_count,
                     e.range_error, out_data_o.range_error);
        end
      end
    end
  end

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_write_read();
    send_access(OP_READ, 16'd0, 2'd0);
    send_access(OP_WRITE, 16'd0, TRIT_TRUE);
    send_access(OP_WRITE, 16'd1023, TRIT_FALSE);
    send_access(OP_WRITE, 16'd500, 2'd3);
  endtask

  task automatic test_count();
    send_access(OP_COUNT, 16'd3, 2'd3);
    send_access(OP_COUNT, 16'd3, TRIT_TRUE);
    send_access(OP_COUNT, 16'd3, TRIT_FALSE);
  endtask

  task automatic test_logic_ops();
    send_access(OP_AND, 16'd0, TRIT_UNK);
    send_access(OP_OR, 16'd1, TRIT_TRUE);
    send_access(OP_NOT, 16'd1, 2'd0);
    send_access(3'd7, 16'd1, 2'd2);
  endtask

  task automatic test_range_errors();
    send_access(OP_WRITE, 16'd1023, TRIT_UNK);
    send_access(OP_WRITE, 16'd1024, TRIT_TRUE);
    send_access(OP_COUNT, 16'hFFFF, TRIT_TRUE);
    send_access(OP_TRIM, 16'hFFFF, 2'd1);
  endtask

  task automatic test_trim();
    send_access(OP_WRITE, 16'd900, TRIT_TRUE);
    send_access(OP_TRIM, 16'd950, 2'd0);
    send_access(OP_TRIM, 16'd1, 2'd0);
    send_access(OP_NOT, 16'd0, 2'd0);
    send_access(OP_TRIM, 16'd0, 2'd0);
    drain_results();
  endtask

  task automatic test_random(int unsigned n);
    logic [15:0] pos;
    for (int unsigned k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: pos = 16'($urandom);
        1: pos = 16'd1023 - 16'($urandom_range(3));
        default: pos = 16'($urandom_range(63));
      endcase
      rx_busy = (k % 100) < 70;
      send_access(3'($urandom_range(7)), pos,
                  ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2)));
      if (k == n / 2) drain_results();
    end
  endtask

  initial begin
    mismatches  = 0;
    rx_busy     = 1'b1;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    for (int i = 0; i < Depth; i++) shadow_trits[i] = TRIT_UNK;
    shadow_len = 0;
    shadow_false = 0;
    shadow_true = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_write_read();
    test_count();
    test_logic_ops();
    test_range_errors();
    test_trim();
    test_random(480);
    drain_results();
    repeat (2200) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ternary_kleene_store test passed");
    end else begin
      $display("ternary_kleene_store test failed");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("ternary_kleene_store test failed");
    $finish;
  end

endmodule
